@@ rtl/core/dtp_pkg.sv @@
// Shared types and constants for the delay timer pool.
package dtp_pkg;

  // Field widths fixed by the command and result words.
  localparam int OP_W     = 3;
  localparam int BANK_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int DELAY_W  = 16;
  localparam int MASK_W   = 10;

  // Default geometry of the pool.
  localparam int SLOTS_PER_BANK_DEF = 10;
  localparam int NUM_BANKS_DEF      = 4;

  // Command codes.
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_RESTART = 3'd3,
    OP_CLEAR   = 3'd4
  } dtp_op_t;

  // Command word.
  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [BANK_W-1:0]  bank;
    logic [SLOT_W-1:0]  slot_index;
    logic [DELAY_W-1:0] delay_ticks;
  } dtp_in_t;

  // Result word.
  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic              success;
    logic [MASK_W-1:0] done_mask;
  } dtp_out_t;

  // Command as broadcast to the cells of one bank.
  typedef struct packed {
    logic               sel;
    logic [OP_W-1:0]    opcode;
    logic [SLOT_W-1:0]  slot_index;
    logic [DELAY_W-1:0] delay_ticks;
  } dtp_bank_cmd_t;

  // Free-slot search carried from one cell to the next.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } dtp_link_t;

endpackage

@@ rtl/core/delay_timer_pool.sv @@
// Top level of the delay timer pool: command decode, banks of slot cells and result register.
//
// A pool of countdown slots in NUM_BANKS banks of SLOTS_PER_BANK slots each.
// A command word on in_word is taken at a clock edge where start is high and
// busy is low. It ticks a bank, allocates the bank's first free slot, releases
// or restarts one slot, or clears the whole bank.
// The cycle after acceptance busy is high while the command is applied to the
// addressed bank; at the end of that cycle every slot cell updates at once and
// the result word is registered. The cycle after that, out_strobe is high for
// exactly one cycle with out_word, which carries the granted slot, the success
// flag and the done flags of the addressed bank after the command.
// A new command may be accepted in the strobe cycle, but not while busy is high.
// Between acceptance and the strobe lie the command register in front of the
// cells and the result register behind them; the allocation search ripples
// through the row of cells combinationally in the execute cycle.
// The receiver cannot stall: each result is shown for one cycle only.
// Synchronous reset frees every slot, clears all counts and done flags, and
// drops busy and out_strobe.
module delay_timer_pool #(
  parameter int SLOTS_PER_BANK = dtp_pkg::SLOTS_PER_BANK_DEF,
  parameter int NUM_BANKS      = dtp_pkg::NUM_BANKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dtp_pkg::dtp_in_t  in_word,
  output logic              out_strobe,
  output dtp_pkg::dtp_out_t out_word
);
  import dtp_pkg::*;

  dtp_in_t   cmd_r;
  logic      exec_r;
  logic      strobe_r;
  dtp_out_t  out_r, out_nxt;

  logic [NUM_BANKS-1:0]      bank_sel;
  logic [NUM_BANKS-1:0]      bank_grabbed;
  logic [NUM_BANKS-1:0]      bank_slot_ok;
  logic [SLOT_W-1:0]         bank_grant [NUM_BANKS];
  logic [SLOTS_PER_BANK-1:0] bank_done  [NUM_BANKS];
  logic [MASK_W-1:0]         bank_mask  [NUM_BANKS];

  logic                      bank_ok;
  logic                      grabbed;
  logic                      slot_ok;
  logic [SLOT_W-1:0]         grant_idx;
  logic [MASK_W-1:0]         mask;

  // Accept a command and hold it for the execute cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      exec_r   <= start && !exec_r;
      strobe_r <= exec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !exec_r) begin
      cmd_r <= in_word;
    end
    if (exec_r) begin
      out_r <= out_nxt;
    end
  end

  // Bank array; only the addressed bank sees a live command.
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    dtp_bank_cmd_t bcmd;

    assign bank_sel[b]      = (b < (1 << BANK_W)) && (cmd_r.bank == BANK_W'(b));
    assign bcmd.sel         = exec_r && bank_sel[b];
    assign bcmd.opcode      = cmd_r.opcode;
    assign bcmd.slot_index  = cmd_r.slot_index;
    assign bcmd.delay_ticks = cmd_r.delay_ticks;

    dtp_bank #(
      .SLOTS_PER_BANK (SLOTS_PER_BANK)
    ) u_bank (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (bcmd),
      .grabbed   (bank_grabbed[b]),
      .grant_idx (bank_grant[b]),
      .slot_ok   (bank_slot_ok[b]),
      .done_nxt  (bank_done[b])
    );

    // Done flags mapped onto the fixed-width mask; slots past the mask are not shown.
    for (genvar j = 0; j < MASK_W; j++) begin : g_mask
      if (j < SLOTS_PER_BANK) begin : g_bit
        assign bank_mask[b][j] = bank_done[b][j];
      end else begin : g_zero
        assign bank_mask[b][j] = 1'b0;
      end
    end
  end

  // Pick out the addressed bank's answers.
  always_comb begin
    bank_ok   = 1'b0;
    grabbed   = 1'b0;
    slot_ok   = 1'b0;
    grant_idx = '0;
    mask      = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (bank_sel[b]) begin
        bank_ok   = 1'b1;
        grabbed   = bank_grabbed[b];
        slot_ok   = bank_slot_ok[b];
        grant_idx = bank_grant[b];
        mask      = bank_mask[b];
      end
    end
  end

  // Result word.
  always_comb begin
    out_nxt.granted_slot = cmd_r.slot_index;
    out_nxt.success      = 1'b0;
    out_nxt.done_mask    = mask;
    if (bank_ok) begin
      unique case (cmd_r.opcode) inside
        OP_TICK, OP_CLEAR: begin
          out_nxt.success = 1'b1;
        end
        OP_ALLOC: begin
          out_nxt.success      = grabbed;
          out_nxt.granted_slot = grabbed ? grant_idx : '0;
        end
        OP_RELEASE, OP_RESTART: begin
          out_nxt.success = slot_ok;
        end
        default: begin
          out_nxt.success = 1'b0;
        end
      endcase
    end
  end

  assign busy       = exec_r;
  assign out_strobe = strobe_r;
  assign out_word   = out_r;

endmodule

@@ rtl/core/dtp_cell.sv @@
// One timer slot: count, in-use and done state plus its link in the free-slot chain.
module dtp_cell #(
  parameter int INDEX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dtp_pkg::dtp_bank_cmd_t cmd,
  input  dtp_pkg::dtp_link_t     link_in,
  output dtp_pkg::dtp_link_t     link_out,
  output logic                  hit,
  output logic                  done_nxt
);
  import dtp_pkg::*;

  logic [DELAY_W-1:0] count_r, count_nxt;
  logic               used_r, used_nxt;
  logic               done_r;
  logic               grab, do_tick, do_take, do_clear;
  logic [DELAY_W-1:0] count_dec;

  // Decode the bank command for this slot.
  assign hit      = (cmd.slot_index == SLOT_W'(INDEX));
  assign grab     = cmd.sel && (cmd.opcode == OP_ALLOC) && !used_r && !link_in.found;
  assign do_tick  = cmd.sel && (cmd.opcode == OP_TICK);
  assign do_take  = grab || (cmd.sel && (cmd.opcode == OP_RESTART) && hit);
  assign do_clear = cmd.sel && (((cmd.opcode == OP_RELEASE) && hit) ||
                                (cmd.opcode == OP_CLEAR));

  // The first free slot claims the allocation and tells the cells after it.
  assign link_out.found = link_in.found || !used_r;
  assign link_out.idx   = grab ? SLOT_W'(INDEX) : link_in.idx;

  assign count_dec = (used_r && (count_r != '0)) ? count_r - 1'b1 : count_r;

  // Next slot state.
  always_comb begin
    count_nxt = count_r;
    used_nxt  = used_r;
    done_nxt  = done_r;
    if (do_tick) begin
      count_nxt = count_dec;
      if (used_r && (count_dec == '0)) begin
        done_nxt = 1'b1;
      end
    end else if (do_take) begin
      count_nxt = cmd.delay_ticks;
      used_nxt  = 1'b1;
      done_nxt  = 1'b0;
    end else if (do_clear) begin
      count_nxt = '0;
      used_nxt  = 1'b0;
      done_nxt  = 1'b0;
    end
  end

  // Slot registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      used_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      used_r  <= used_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

@@ rtl/core/dtp_bank.sv @@
// One bank: a row of slot cells joined by the free-slot search chain.
module dtp_bank #(
  parameter int SLOTS_PER_BANK = dtp_pkg::SLOTS_PER_BANK_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dtp_pkg::dtp_bank_cmd_t       cmd,
  output logic                        grabbed,
  output logic [dtp_pkg::SLOT_W-1:0]  grant_idx,
  output logic                        slot_ok,
  output logic [SLOTS_PER_BANK-1:0]   done_nxt
);
  import dtp_pkg::*;

  dtp_link_t                 link [SLOTS_PER_BANK+1];
  logic [SLOTS_PER_BANK-1:0] hit;

  assign link[0] = '{found: 1'b0, idx: '0};

  // The chain of cells, lowest slot first.
  for (genvar i = 0; i < SLOTS_PER_BANK; i++) begin : g_cell
    dtp_cell #(
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .hit      (hit[i]),
      .done_nxt (done_nxt[i])
    );
  end

  // A free slot existed somewhere in the row, so an allocation succeeded.
  assign grabbed   = link[SLOTS_PER_BANK].found;
  assign grant_idx = link[SLOTS_PER_BANK].idx;
  assign slot_ok   = |hit;

endmodule

@@ rtl/core/delay_timer_pool_chk.sv @@
// Port-level checker for the delay timer pool, bound to the top level.
module delay_timer_pool_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input dtp_pkg::dtp_out_t out_word,
  input logic              out_strobe
);
  import dtp_pkg::*;

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_strobe)
    else $error("busy or strobe after reset");

  // An accepted word makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // Every accepted word yields a strobe with a fully known result word after the busy cycle.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && start && !busy |-> ##2 (out_strobe && !$isunknown(out_word)))
    else $error("known result word missing two cycles after accept");

  // Busy lasts exactly one cycle.
  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // A result strobe follows only a busy cycle.
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy) && !busy)
    else $error("result strobe without a preceding busy cycle");

endmodule

bind delay_timer_pool delay_timer_pool_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_word   (out_word),
  .out_strobe (out_strobe)
);

@@ sim/delay_timer_pool_tb.sv @@
// Self-checking testbench for the delay timer pool: directed and random command words.
`timescale 1ns / 1ps

module delay_timer_pool_tb;
  import dtp_pkg::*;

  localparam int SLOTS          = SLOTS_PER_BANK_DEF;
  localparam int BANKS          = NUM_BANKS_DEF;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int MAX_PRINTED    = 40;
  localparam int DRAIN_CYCLES   = 4;

  // Opcode range that the block does not implement.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  // Tracks the slot state of every bank and checks each result word in order.
  class timer_pool_tracker;
    logic [DELAY_W-1:0] count_q [BANKS][SLOTS];
    bit                 in_use  [BANKS][SLOTS];
    bit                 done    [BANKS][SLOTS];
    dtp_out_t           expected_words[$];
    int unsigned        errors;
    int unsigned        n_commands;
    int unsigned        n_results;
    int unsigned        n_new_done;
    int unsigned        n_alloc_fail;
    int unsigned        n_range_fail;

    function new();
      for (int b = 0; b < BANKS; b++) begin
        for (int i = 0; i < SLOTS; i++) begin
          clear_slot(b, i);
        end
      end
    endfunction

    function void clear_slot(int b, int i);
      count_q[b][i] = '0;
      in_use[b][i]  = 1'b0;
      done[b][i]    = 1'b0;
    endfunction

    function void take_slot(int b, int i, logic [DELAY_W-1:0] ticks);
      count_q[b][i] = ticks;
      in_use[b][i]  = 1'b1;
      done[b][i]    = 1'b0;
    endfunction

    // Applies one command word to the tracked state and returns its result word.
    function dtp_out_t apply_command(dtp_in_t w);
      dtp_out_t r;
      int       b;
      bit       found;
      r.granted_slot = w.slot_index;
      r.success      = 1'b0;
      r.done_mask    = '0;
      b = int'(w.bank);
      found = 1'b0;
      if (b >= BANKS) return r;
      case (w.opcode)
        OP_TICK: begin
          // Running slots count down; any slot in use that sits at zero latches done.
          for (int i = 0; i < SLOTS; i++) begin
            if (in_use[b][i] && count_q[b][i] != '0) count_q[b][i] = count_q[b][i] - 1'b1;
            if (in_use[b][i] && count_q[b][i] == '0) begin
              if (!done[b][i]) n_new_done++;
              done[b][i] = 1'b1;
            end
          end
          r.success = 1'b1;
        end
        OP_ALLOC: begin
          // The lowest free slot is taken; a full bank gives slot zero and a failure.
          r.granted_slot = '0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && !in_use[b][i]) begin
              take_slot(b, i, w.delay_ticks);
              r.granted_slot = SLOT_W'(i);
              r.success      = 1'b1;
              found          = 1'b1;
            end
          end
          if (!found) n_alloc_fail++;
        end
        OP_RELEASE: begin
          if (int'(w.slot_index) < SLOTS) begin
            clear_slot(b, int'(w.slot_index));
            r.success = 1'b1;
          end else begin
            n_range_fail++;
          end
        end
        OP_RESTART: begin
          if (int'(w.slot_index) < SLOTS) begin
            take_slot(b, int'(w.slot_index), w.delay_ticks);
            r.success = 1'b1;
          end else begin
            n_range_fail++;
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < SLOTS; i++) begin
            clear_slot(b, i);
          end
          r.success = 1'b1;
        end
        default: begin
        end
      endcase
      for (int i = 0; i < SLOTS && i < MASK_W; i++) begin
        r.done_mask[i] = done[b][i];
      end
      return r;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("mismatch at result %0d: %s, got %0h, expected %0h",
                 n_results, what, got, want);
      end
    endtask

    // Notes an accepted command word.
    function void note_command(dtp_in_t w);
      n_commands++;
      expected_words.push_back(apply_command(w));
    endfunction

    // Compares a result word with the oldest expected one.
    task check_result(dtp_out_t got);
      dtp_out_t want;
      n_results++;
      if (expected_words.size() == 0) begin
        report_mismatch("result word with no command outstanding", 32'(got), 0);
      end else begin
        want = expected_words.pop_front();
        if (got.granted_slot !== want.granted_slot)
          report_mismatch("granted_slot", 32'(got.granted_slot), 32'(want.granted_slot));
        if (got.success !== want.success)
          report_mismatch("success", 32'(got.success), 32'(want.success));
        if (got.done_mask !== want.done_mask)
          report_mismatch("done_mask", 32'(got.done_mask), 32'(want.done_mask));
      end
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  dtp_in_t  in_word;
  logic     out_strobe;
  dtp_out_t out_word;

  timer_pool_tracker tracker;
  int unsigned       idle_cycles = 0;
  bit                no_idle_phase;

  delay_timer_pool u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  // 50 MHz clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Monitor: checks result words first, since a new command may be taken in the strobe cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1) tracker.check_result(out_word);
      if (start && busy === 1'b0) tracker.note_command(in_word);
      if (out_strobe === 1'b1 || (start && busy === 1'b0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic dtp_in_t make_cmd(logic [OP_W-1:0] op, logic [BANK_W-1:0] bank,
                                       logic [SLOT_W-1:0] slot, logic [DELAY_W-1:0] ticks);
    dtp_in_t w;
    w.opcode      = op;
    w.bank        = bank;
    w.slot_index  = slot;
    w.delay_ticks = ticks;
    return w;
  endfunction

  // Mostly short gaps, a few long ones, none during a back-to-back stretch.
  function automatic int unsigned next_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (no_idle_phase || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Well-formed traffic with small delays so slots run out, plus noise.
  function automatic dtp_in_t random_command();
    dtp_in_t     w;
    int unsigned pick;
    w.bank        = BANK_W'($urandom_range(0, BANKS - 1));
    w.delay_ticks = DELAY_W'($urandom);
    w.slot_index  = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(SLOTS, 15))
                                                : SLOT_W'($urandom_range(0, SLOTS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 38) w.opcode = OP_TICK;
    else if (pick < 62) w.opcode = OP_ALLOC;
    else if (pick < 77) w.opcode = OP_RELEASE;
    else if (pick < 92) w.opcode = OP_RESTART;
    else if (pick < 96) w.opcode = OP_CLEAR;
    else w.opcode = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if (w.opcode == OP_ALLOC || w.opcode == OP_RESTART) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) w.delay_ticks = DELAY_W'($urandom_range(0, 6));
      else if (pick < 95) w.delay_ticks = DELAY_W'($urandom_range(7, 40));
    end
    return w;
  endfunction

  // Presents one command word after a gap and returns at the edge that accepts it.
  task automatic send_command(input dtp_in_t w, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Holds the sender off until every outstanding result word has arrived.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending() > 0);
  endtask

  initial begin
    dtp_in_t     w;
    int unsigned useful;
    tracker       = new();
    no_idle_phase = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_word       = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty tick, zero and full delays, range errors, a full bank, unused opcodes.
    send_command(make_cmd(OP_TICK,    2'd0, 4'd0,  16'd0),     next_gap());
    send_command(make_cmd(OP_ALLOC,   2'd0, 4'd15, 16'd0),     next_gap());
    send_command(make_cmd(OP_ALLOC,   2'd0, 4'd0,  16'hFFFF),  next_gap());
    send_command(make_cmd(OP_ALLOC,   2'd0, 4'd0,  16'd1),     next_gap());
    send_command(make_cmd(OP_TICK,    2'd0, 4'd15, 16'hFFFF),  next_gap());
    send_command(make_cmd(OP_RELEASE, 2'd0, 4'd1,  16'd0),     next_gap());
    send_command(make_cmd(OP_RELEASE, 2'd0, 4'd5,  16'd0),     next_gap());
    send_command(make_cmd(OP_RELEASE, 2'd0, 4'd15, 16'd0),     next_gap());
    send_command(make_cmd(OP_RESTART, 2'd0, 4'd10, 16'd3),     next_gap());
    send_command(make_cmd(OP_RESTART, 2'd0, 4'd3,  16'd2),     next_gap());
    send_command(make_cmd(OP_RESTART, 2'd0, 4'd0,  16'd0),     next_gap());
    send_command(make_cmd(OP_TICK,    2'd0, 4'd0,  16'd0),     next_gap());
    for (int i = 0; i <= SLOTS; i++) begin
      send_command(make_cmd(OP_ALLOC, 2'd1, 4'(i), 16'(i)), next_gap());
    end
    send_command(make_cmd(OP_CLEAR,    2'd1, 4'd0, 16'd0), next_gap());
    send_command(make_cmd(OP_UNUSED_LO, 2'd0, 4'd0, 16'd0), next_gap());
    send_command(make_cmd(OP_UNUSED_HI, 2'd3, 4'd9, 16'd0), next_gap());
    send_command(make_cmd(OP_TICK,     2'd3, 4'd0, 16'd0), next_gap());

    // Random traffic in phases, some of them back to back.
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      no_idle_phase = ((useful / 150) % 3) == 1;
      w = random_command();
      send_command(w, next_gap());
      if (w.opcode <= OP_CLEAR) useful++;
      if (useful == RANDOM_ITEMS / 2) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (tracker.pending() > 0) begin
      w = '0;
      void'(tracker.expected_words.pop_front());
      tracker.report_mismatch("no result word for command", 0, 1);
    end

    $display("covered %0d command words and %0d result words over %0d banks",
             tracker.n_commands, tracker.n_results, BANKS);
    $display("%0d done flags raised by ticks, %0d refused allocations, %0d bad slot indexes",
             tracker.n_new_done, tracker.n_alloc_fail, tracker.n_range_fail);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
